@@ src/pam_pkg.sv @@
// ----------------------------------------------------------------------------
// pam_pkg: shared definitions for the polynomial add/multiply block
// Request codes, field widths, and controller/datapath command and status words.
// ----------------------------------------------------------------------------
package pam_pkg;

    localparam int MAX_EXP_DEF = 15;
    localparam int FUNC_W      = 3;
    localparam int COEF_W      = 32;
    localparam int EXP_W       = 4;
    localparam int TERM_EXP_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUM    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PROD   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    typedef struct packed {
        logic ld_rd;      // read a store for a term load
        logic ld_sel;     // load target: 0 first, 1 second
        logic ld_wr;      // write back the loaded term
        logic clr_all;    // empty all stores
        logic res_clr;    // empty the result store
        logic pair_go;    // issue one coefficient pair into the pipeline
        logic pair_last;  // pair closes its result exponent
        logic pair_prod;  // multiply (1) or add (0) the pair
        logic emit_rd;    // read the result store at the scan index
        logic out_load;   // load the output register
        logic out_last;   // word is the final term
        logic out_empty;  // word flags an empty result
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;  // pairs still in flight
        logic res_any;    // some result term present
        logic res_hit;    // result term present at the scan index
        logic res_below;  // result term present below the scan index
        logic out_free;   // output register can take a word
    } t_stat;

endpackage

@@ src/polynomial_add_multiply_top.sv @@
// ----------------------------------------------------------------------------
// polynomial_add_multiply_top: sparse polynomial sum and product engine
// Two term stores, a pair pipeline with one multiplier, and a result scanner.
// ----------------------------------------------------------------------------
// Usage and timing: every request takes one input word and holds off the next
// word until it is done. A term load (func 0 or 1) reads the target store,
// then writes the merged coefficient back. Clear is done and unused codes are
// dropped in the idle state, as their word is taken. A sum walks MAX_EXP+1 exponents,
// one a cycle, and a product walks all (MAX_EXP+1)^2 term pairs, one a cycle
// through a three-stage add/multiply/accumulate pipeline grouped by result
// exponent; then the pipeline drains and the block checks for any present term.
// The result is then scanned from exponent 2*MAX_EXP down, stepping past each
// absent exponent and giving each emitted word a store read and an output load,
// ending at the lowest present term; an empty result gives one flagged word.
// The single multiplier and the one-pair-per-cycle store read ports set the
// product time. Results leave through an output register, so the next request
// is accepted while the final word still waits on o_out_valid/i_out_stall.
// A word is moved on an edge where valid is high and stall is low.
// ----------------------------------------------------------------------------
module polynomial_add_multiply_top #(
    parameter int MAX_EXP = pam_pkg::MAX_EXP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [pam_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [pam_pkg::COEF_W-1:0]    i_coef,
    input  logic [pam_pkg::EXP_W-1:0]            i_exp,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pam_pkg::COEF_W-1:0]    o_term_coef,
    output logic [pam_pkg::TERM_EXP_W-1:0]       o_term_exp,
    output logic                                 o_last,
    output logic                                 o_empty_res
);
    import pam_pkg::*;

    localparam int TW = $clog2(MAX_EXP + 1);
    localparam int RW = $clog2(2 * MAX_EXP + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [TW-1:0] pair_a, pair_b;
    logic [RW-1:0] pair_k, scan;

    // sequencer: decode requests, walk exponent pairs, scan the result
    pam_ctrl #(
        .MAX_EXP (MAX_EXP)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_pair_a   (pair_a),
        .o_pair_b   (pair_b),
        .o_pair_k   (pair_k),
        .o_scan     (scan)
    );

    // datapath: stores, add/multiply pipeline, output register
    pam_dp #(
        .MAX_EXP (MAX_EXP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_coef      (i_coef),
        .i_exp       (i_exp),
        .i_pair_a    (pair_a),
        .i_pair_b    (pair_b),
        .i_pair_k    (pair_k),
        .i_scan      (scan),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_term_coef (o_term_coef),
        .o_term_exp  (o_term_exp),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

endmodule

@@ src/pam_ctrl.sv @@
// ----------------------------------------------------------------------------
// pam_ctrl: request sequencer
// Decodes requests, walks exponent pairs for sum and product, scans the result.
// ----------------------------------------------------------------------------
module pam_ctrl #(
    parameter int MAX_EXP = pam_pkg::MAX_EXP_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic [pam_pkg::FUNC_W-1:0]        i_func,
    input  pam_pkg::t_stat                    i_stat,
    output logic                              o_in_stall,
    output pam_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_EXP+1)-1:0]      o_pair_a,
    output logic [$clog2(MAX_EXP+1)-1:0]      o_pair_b,
    output logic [$clog2(2*MAX_EXP+1)-1:0]    o_pair_k,
    output logic [$clog2(2*MAX_EXP+1)-1:0]    o_scan
);
    import pam_pkg::*;

    localparam int NTERM = MAX_EXP + 1;
    localparam int NRES  = 2 * MAX_EXP + 1;
    localparam int TW    = $clog2(NTERM);
    localparam int RW    = $clog2(NRES);

    localparam logic [RW-1:0] MAX_R  = RW'(MAX_EXP);
    localparam logic [RW-1:0] LAST_K = RW'(NRES - 1);
    localparam logic [RW-1:0] ONE_R  = RW'(1);
    localparam logic [TW-1:0] ONE_T  = TW'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_PROD  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [RW-1:0] r_k, n_k;
    logic [RW-1:0] r_scan, n_scan;
    logic [TW-1:0] r_i, n_i;

    logic [RW-1:0] idx_ext;
    logic [RW-1:0] k_hi;
    logic [RW-1:0] k_nxt;
    logic [RW-1:0] lo_nxt;
    logic          diag_end;

    // first index i of diagonal k runs from max(0, k-MAX) to min(k, MAX)
    assign idx_ext  = RW'(r_i);
    assign k_hi     = (r_k < MAX_R) ? r_k : MAX_R;
    assign diag_end = (idx_ext == k_hi);
    assign k_nxt    = r_k + ONE_R;
    assign lo_nxt   = (k_nxt > MAX_R) ? (k_nxt - MAX_R) : '0;

    assign o_pair_k = r_k;
    assign o_scan   = r_scan;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_i        = r_i;
        n_scan     = r_scan;
        o_cmd      = '0;
        o_pair_a   = r_i;
        o_pair_b   = TW'(r_k - idx_ext);
        o_in_stall = (r_state != S_IDLE) || !i_rst_n;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    unique case (i_func) inside
                        FUNC_LOAD_A, FUNC_LOAD_B: begin
                            o_cmd.ld_rd  = 1'b1;
                            o_cmd.ld_sel = (i_func == FUNC_LOAD_B);
                            n_state      = S_LOAD;
                        end
                        FUNC_SUM: begin
                            o_cmd.res_clr = 1'b1;
                            n_k           = '0;
                            n_state       = S_SUM;
                        end
                        FUNC_PROD: begin
                            o_cmd.res_clr = 1'b1;
                            n_k           = '0;
                            n_i           = '0;
                            n_state       = S_PROD;
                        end
                        FUNC_CLEAR: begin
                            o_cmd.clr_all = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.ld_wr = 1'b1;
                n_state     = S_IDLE;
            end
            S_SUM: begin
                o_cmd.pair_go   = 1'b1;
                o_cmd.pair_last = 1'b1;
                o_pair_a        = TW'(r_k);
                o_pair_b        = TW'(r_k);
                if (r_k == MAX_R) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = k_nxt;
                end
            end
            S_PROD: begin
                o_cmd.pair_go   = 1'b1;
                o_cmd.pair_prod = 1'b1;
                o_cmd.pair_last = diag_end;
                if (diag_end) begin
                    if (r_k == LAST_K) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_k = k_nxt;
                        n_i = TW'(lo_nxt);
                    end
                end else begin
                    n_i = r_i + ONE_T;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    if (i_stat.res_any) begin
                        n_scan  = LAST_K;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_empty = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.res_hit) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    n_scan = r_scan - ONE_R;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = !i_stat.res_below;
                    if (!i_stat.res_below) begin
                        n_state = S_IDLE;
                    end else begin
                        n_scan  = r_scan - ONE_R;
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_scan  <= n_scan;
        end
    end

    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (!i_stat.pipe_busy && i_stat.res_any))
        else $error("result scan started with pairs in flight or no terms");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_wr |-> $past(o_cmd.ld_rd))
        else $error("term write-back without a preceding store read");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROD) |-> ((r_k >= idx_ext) && ((r_k - idx_ext) <= MAX_R)))
        else $error("product pair index out of range");

endmodule

@@ src/pam_dp.sv @@
// ----------------------------------------------------------------------------
// pam_dp: coefficient datapath
// Term stores, pair add/multiply pipeline, diagonal accumulator, output register.
// ----------------------------------------------------------------------------
module pam_dp #(
    parameter int MAX_EXP = pam_pkg::MAX_EXP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pam_pkg::t_cmd                        i_cmd,
    input  logic signed [pam_pkg::COEF_W-1:0]    i_coef,
    input  logic [pam_pkg::EXP_W-1:0]            i_exp,
    input  logic [$clog2(MAX_EXP+1)-1:0]         i_pair_a,
    input  logic [$clog2(MAX_EXP+1)-1:0]         i_pair_b,
    input  logic [$clog2(2*MAX_EXP+1)-1:0]       i_pair_k,
    input  logic [$clog2(2*MAX_EXP+1)-1:0]       i_scan,
    input  logic                                 i_out_stall,
    output pam_pkg::t_stat                       o_stat,
    output logic                                 o_out_valid,
    output logic signed [pam_pkg::COEF_W-1:0]    o_term_coef,
    output logic [pam_pkg::TERM_EXP_W-1:0]       o_term_exp,
    output logic                                 o_last,
    output logic                                 o_empty_res
);
    import pam_pkg::*;

    localparam int NTERM = MAX_EXP + 1;
    localparam int NRES  = 2 * MAX_EXP + 1;
    localparam int TW    = $clog2(NTERM);
    localparam int RW    = $clog2(NRES);

    logic [COEF_W-1:0] r_first_mem  [NTERM];
    logic [COEF_W-1:0] r_second_mem [NTERM];
    logic [COEF_W-1:0] r_res_mem    [NRES];
    logic [NTERM-1:0]  r_first_pres;
    logic [NTERM-1:0]  r_second_pres;
    logic [NRES-1:0]   r_res_pres;
    logic [COEF_W-1:0] r_f_rd, r_s_rd, r_res_rd;

    logic              r_ld_sel, r_ld_ok;
    logic [TW-1:0]     r_ld_addr;
    logic [COEF_W-1:0] r_ld_coef;

    logic              r_p0_valid, r_p0_last, r_p0_prod, r_p0_fp, r_p0_sp;
    logic [RW-1:0]     r_p0_k;
    logic              r_p1_valid, r_p1_last, r_p1_hit;
    logic [RW-1:0]     r_p1_k;
    logic [COEF_W-1:0] r_p1_val;
    logic [COEF_W-1:0] r_acc;
    logic              r_acc_hit;

    logic              r_out_valid, r_out_last, r_out_empty;
    logic [COEF_W-1:0] r_out_coef;
    logic [TERM_EXP_W-1:0] r_out_exp;

    logic [TW-1:0]     ld_addr, f_addr, s_addr;
    logic              ld_ok, ld_hit;
    logic [COEF_W-1:0] ld_old, ld_val;
    logic [COEF_W-1:0] val_sum, val_prod;
    logic [COEF_W-1:0] acc_nxt;
    logic              hit_nxt;
    logic [NRES-1:0]   below_mask;

    // term load: read the target store, then write back the merged coefficient
    assign ld_addr = TW'(i_exp);
    assign ld_ok   = (32'(i_exp) <= 32'(MAX_EXP));
    assign f_addr  = i_cmd.ld_rd ? ld_addr : i_pair_a;
    assign s_addr  = i_cmd.ld_rd ? ld_addr : i_pair_b;
    assign ld_old  = r_ld_sel ? r_s_rd : r_f_rd;
    assign ld_hit  = r_ld_sel ? r_second_pres[r_ld_addr] : r_first_pres[r_ld_addr];
    assign ld_val  = ld_hit ? (ld_old + r_ld_coef) : r_ld_coef;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_rd) begin
            r_ld_sel  <= i_cmd.ld_sel;
            r_ld_ok   <= ld_ok;
            r_ld_addr <= ld_addr;
            r_ld_coef <= i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr && r_ld_ok && !r_ld_sel) begin
            r_first_mem[r_ld_addr] <= ld_val;
        end
        r_f_rd <= r_first_mem[f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr && r_ld_ok && r_ld_sel) begin
            r_second_mem[r_ld_addr] <= ld_val;
        end
        r_s_rd <= r_second_mem[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_first_pres  <= '0;
            r_second_pres <= '0;
        end else if (i_cmd.ld_wr && r_ld_ok) begin
            if (r_ld_sel) begin
                r_second_pres[r_ld_addr] <= 1'b1;
            end else begin
                r_first_pres[r_ld_addr] <= 1'b1;
            end
        end
    end

    // stage 0: store read in flight, carry presence and diagonal tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else begin
            r_p0_valid <= i_cmd.pair_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_go) begin
            r_p0_last <= i_cmd.pair_last;
            r_p0_prod <= i_cmd.pair_prod;
            r_p0_k    <= i_pair_k;
            r_p0_fp   <= r_first_pres[i_pair_a];
            r_p0_sp   <= r_second_pres[i_pair_b];
        end
    end

    // stage 1: add or multiply the pair
    assign val_sum  = (r_p0_fp ? r_f_rd : '0) + (r_p0_sp ? r_s_rd : '0);
    assign val_prod = r_f_rd * r_s_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= r_p0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p0_valid) begin
            r_p1_last <= r_p0_last;
            r_p1_k    <= r_p0_k;
            r_p1_val  <= r_p0_prod ? val_prod : val_sum;
            r_p1_hit  <= r_p0_prod ? (r_p0_fp && r_p0_sp) : (r_p0_fp || r_p0_sp);
        end
    end

    // stage 2: accumulate along the diagonal, write the term when it closes
    assign acc_nxt = r_acc + (r_p1_hit ? r_p1_val : '0);
    assign hit_nxt = r_acc_hit || r_p1_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clr) begin
            r_acc <= '0;
        end else if (r_p1_valid) begin
            r_acc <= r_p1_last ? '0 : acc_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.res_clr) begin
            r_acc_hit <= 1'b0;
        end else if (r_p1_valid) begin
            r_acc_hit <= r_p1_last ? 1'b0 : hit_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid && r_p1_last) begin
            r_res_mem[r_p1_k] <= acc_nxt;
        end
        if (i_cmd.emit_rd) begin
            r_res_rd <= r_res_mem[i_scan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all || i_cmd.res_clr) begin
            r_res_pres <= '0;
        end else if (r_p1_valid && r_p1_last && hit_nxt) begin
            r_res_pres[r_p1_k] <= 1'b1;
        end
    end

    always_comb begin
        for (int b = 0; b < NRES; b++) begin
            below_mask[b] = (RW'(b) < i_scan);
        end
    end

    assign o_stat.pipe_busy = r_p0_valid || r_p1_valid;
    assign o_stat.res_any   = |r_res_pres;
    assign o_stat.res_hit   = r_res_pres[i_scan];
    assign o_stat.res_below = |(r_res_pres & below_mask);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_coef  <= i_cmd.out_empty ? '0 : r_res_rd;
            r_out_exp   <= i_cmd.out_empty ? '0 : TERM_EXP_W'(i_scan);
            r_out_last  <= i_cmd.out_last;
            r_out_empty <= i_cmd.out_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_term_coef = $signed(r_out_coef);
    assign o_term_exp  = r_out_exp;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while its word is stalled");

    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_clr |=> (r_res_pres == '0))
        else $error("result store not empty after result clear");

    a_acc_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && r_p1_last) |=> !r_acc_hit)
        else $error("accumulator carried presence past a closed diagonal");

endmodule

@@ verif/polynomial_add_multiply_top_tb.sv @@
// ----------------------------------------------------------------------------
// polynomial_add_multiply_top_tb: self-checking bench for the polynomial engine
// Drives term loads, sum, product, clear and spare requests. A built-in model
// predicts every result word, and each word leaving the block is checked
// against it. The run uses several idle/stall mixes and one long output hold.
// ----------------------------------------------------------------------------
module polynomial_add_multiply_top_tb;
    import pam_pkg::*;

    localparam int NTERM          = MAX_EXP_DEF + 1;
    localparam int NRES           = 2 * MAX_EXP_DEF + 1;
    localparam int RANDOM_WORDS   = 176;
    localparam int LONG_HOLD      = 600;   // output hold-off for the pressure stretch
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 64;

    // Codes 5..7 carry no meaning; the block must drop them silently.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [COEF_W-1:0]     coef;
        logic [TERM_EXP_W-1:0] exp;
        logic                  last;
        logic                  empty;
    } poly_term_t;

    // ------------------------------------------------------------------------
    // Polynomial tracker: mirrors both term stores, builds each sum/product
    // result and keeps the words still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class poly_tracker;
        bit [COEF_W-1:0] poly_coef [2][NTERM];
        bit              poly_have [2][NTERM];
        bit [COEF_W-1:0] res_coef [NRES];
        bit              res_have [NRES];
        poly_term_t      owed_terms [$];
        int              errors;
        int              requests;
        int              sums;
        int              products;
        int              empties;
        int              words_checked;

        function void accumulate(int e, bit [COEF_W-1:0] v);
            if (res_have[e]) begin
                res_coef[e] += v;
            end else begin
                res_coef[e] = v;
                res_have[e] = 1'b1;
            end
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [COEF_W-1:0] c,
                                   logic [EXP_W-1:0] e);
            poly_term_t t;
            int         n;
            int         idx;
            requests++;
            case (f)
                FUNC_LOAD_A, FUNC_LOAD_B: begin
                    idx = (f == FUNC_LOAD_B) ? 1 : 0;
                    if (poly_have[idx][e]) begin
                        poly_coef[idx][e] += c;
                    end else begin
                        poly_coef[idx][e] = c;
                        poly_have[idx][e] = 1'b1;
                    end
                end
                FUNC_SUM, FUNC_PROD: begin
                    foreach (res_have[k]) begin
                        res_have[k] = 1'b0;
                        res_coef[k] = '0;
                    end
                    if (f == FUNC_SUM) begin
                        sums++;
                        for (int i = 0; i < NTERM; i++) begin
                            if (poly_have[0][i]) accumulate(i, poly_coef[0][i]);
                            if (poly_have[1][i]) accumulate(i, poly_coef[1][i]);
                        end
                    end else begin
                        products++;
                        for (int i = 0; i < NTERM; i++) begin
                            for (int j = 0; j < NTERM; j++) begin
                                if (poly_have[0][i] && poly_have[1][j])
                                    accumulate(i + j, poly_coef[0][i] * poly_coef[1][j]);
                            end
                        end
                    end
                    // Emit highest exponent first; flag the final word.
                    n = 0;
                    for (int k = NRES - 1; k >= 0; k--) begin
                        if (res_have[k]) begin
                            t.coef  = res_coef[k];
                            t.exp   = TERM_EXP_W'(k);
                            t.last  = 1'b0;
                            t.empty = 1'b0;
                            owed_terms.push_back(t);
                            n++;
                        end
                    end
                    if (n == 0) begin
                        empties++;
                        t = '0;
                        t.empty = 1'b1;
                        owed_terms.push_back(t);
                    end else begin
                        owed_terms[owed_terms.size() - 1].last = 1'b1;
                    end
                end
                FUNC_CLEAR: begin
                    foreach (poly_have[p, k]) begin
                        poly_have[p][k] = 1'b0;
                        poly_coef[p][k] = '0;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_term(logic [COEF_W-1:0] c, logic [TERM_EXP_W-1:0] e,
                                 logic l, logic z);
            poly_term_t want;
            words_checked++;
            if (owed_terms.size() == 0) begin
                $error("unexpected result word: term_coef %0d term_exp %0d last %0b empty_res %0b",
                       $signed(c), e, l, z);
                errors++;
            end else begin
                want = owed_terms.pop_front();
                if (c !== want.coef) begin
                    $error("term_coef: expected %0d, got %0d", $signed(want.coef), $signed(c));
                    errors++;
                end
                if (e !== want.exp) begin
                    $error("term_exp: expected %0d, got %0d", want.exp, e);
                    errors++;
                end
                if (l !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, l);
                    errors++;
                end
                if (z !== want.empty) begin
                    $error("empty_res: expected %0b, got %0b", want.empty, z);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [FUNC_W-1:0]        i_func;
    logic signed [COEF_W-1:0] i_coef;
    logic [EXP_W-1:0]         i_exp;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [COEF_W-1:0] o_term_coef;
    logic [TERM_EXP_W-1:0]    o_term_exp;
    logic                     o_last;
    logic                     o_empty_res;

    poly_tracker tracker = new();

    // Idle mix for the current phase, in percent per cycle.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // Raised by the stimulus to ask the receiver for its one long hold-off.
    bit pressure_req = 1'b0;

    polynomial_add_multiply_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_coef      (i_coef),
        .i_exp       (i_exp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_term_coef (o_term_coef),
        .o_term_exp  (o_term_exp),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one request word from the falling edge, with random idle cycles
    // in front of it, and hold it until the block takes it.
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [COEF_W-1:0] c,
                             input logic [EXP_W-1:0] e);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func     = f;
        i_coef     = c;
        i_exp      = e;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(f, c, e);
    endtask

    // Coefficient mix: small values so sums and products stay readable,
    // full-range values, and the wrap-around corners.
    function automatic logic [COEF_W-1:0] pick_coef();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return COEF_W'($urandom_range(0, 40)) - COEF_W'(20);
        if (sel < 8)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Receiver: check each word that moves, then pick the stall for the
    // next cycle at the falling edge. The long hold-off is counted here.
    initial begin
        int hold_left;
        bit pressure_served;
        hold_left       = 0;
        pressure_served = 1'b0;
        i_out_stall     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                tracker.check_term(o_term_coef, o_term_exp, o_last, o_empty_res);
            @(negedge i_clk);
            if (pressure_req && !pressure_served) begin
                hold_left       = LONG_HOLD;
                pressure_served = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < receiver_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int          random_sent;
        int          phase;
        int          n_loads;
        logic [FUNC_W-1:0] f;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_func     = FUNC_LOAD_A;
        i_coef     = '0;
        i_exp      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- Directed part ---------------------------------------------------
        // Requests on empty stores must each give a single empty-flagged word.
        send_word(FUNC_SUM,  32'h1234_5678, 4'd9);
        send_word(FUNC_PROD, 32'hdead_beef, 4'd6);
        // Spare codes: drop, no words.
        for (int k = FUNC_SPARE_LO; k <= FUNC_SPARE_HI; k++)
            send_word(FUNC_W'(k), $urandom, EXP_W'($urandom_range(0, 15)));
        // Extreme coefficients at the extreme exponents; a repeat load at
        // exponent 15 merges and wraps past the positive limit.
        send_word(FUNC_LOAD_A, 32'h7fff_ffff, 4'd15);
        send_word(FUNC_LOAD_A, 32'h8000_0000, 4'd0);
        send_word(FUNC_LOAD_A, 32'h0000_0001, 4'd15);
        send_word(FUNC_LOAD_B, 32'hffff_ffff, 4'd15);
        send_word(FUNC_LOAD_B, 32'h8000_0000, 4'd0);
        // Sum: exponent 0 wraps to zero and must still be emitted.
        send_word(FUNC_SUM,  '0, '0);
        send_word(FUNC_PROD, '0, '0);
        // A zero coefficient and a pair that cancels stay present.
        send_word(FUNC_LOAD_B, 32'h0000_0000, 4'd7);
        send_word(FUNC_LOAD_A, 32'd5, 4'd3);
        send_word(FUNC_LOAD_A, -32'sd5, 4'd3);
        send_word(FUNC_SUM,  '0, '0);
        send_word(FUNC_PROD, '0, '0);
        // Clear empties everything.
        send_word(FUNC_CLEAR, '1, '1);
        send_word(FUNC_SUM,   '0, '0);
        // Only the first polynomial loaded: product empty, sum one term.
        send_word(FUNC_LOAD_A, 32'd3, 4'd2);
        send_word(FUNC_PROD,   '0, '0);
        send_word(FUNC_SUM,    '0, '0);
        send_word(FUNC_CLEAR,  '0, '0);

        // --- Pressure: hold the output off while requests keep coming --------
        pressure_req = 1'b1;
        for (int k = 0; k < 6; k++)
            send_word((k % 2) ? FUNC_LOAD_B : FUNC_LOAD_A, pick_coef(),
                      EXP_W'($urandom_range(0, 15)));
        send_word(FUNC_SUM,  '0, '0);
        send_word(FUNC_PROD, '0, '0);
        send_word(FUNC_SUM,  '0, '0);
        send_word(FUNC_PROD, '0, '0);
        pressure_req = 1'b0;

        // --- Random part -----------------------------------------------------
        // Mostly load runs closed by a sum and/or product; some noise words.
        random_sent = 0;
        while (random_sent < RANDOM_WORDS) begin
            phase = random_sent * 4 / RANDOM_WORDS;
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
            endcase
            if ($urandom_range(0, 99) < 10) begin
                f = FUNC_W'($urandom_range(0, 7));
                send_word(f, pick_coef(), EXP_W'($urandom_range(0, 15)));
                if (f < FUNC_SPARE_LO)
                    random_sent++;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    send_word(FUNC_CLEAR, $urandom, EXP_W'($urandom_range(0, 15)));
                    random_sent++;
                end
                n_loads = $urandom_range(1, 8);
                repeat (n_loads) begin
                    send_word($urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A,
                              pick_coef(), EXP_W'($urandom_range(0, 15)));
                    random_sent++;
                end
                case ($urandom_range(0, 2))
                    0: send_word(FUNC_SUM, $urandom, EXP_W'($urandom_range(0, 15)));
                    1: send_word(FUNC_PROD, $urandom, EXP_W'($urandom_range(0, 15)));
                    default: begin
                        send_word(FUNC_SUM, $urandom, EXP_W'($urandom_range(0, 15)));
                        send_word(FUNC_PROD, $urandom, EXP_W'($urandom_range(0, 15)));
                        random_sent++;
                    end
                endcase
                random_sent++;
            end
        end

        // --- Wind down -------------------------------------------------------
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.owed_terms.size() != 0)
            @(posedge i_clk);
        // Hold a little longer to catch stray words.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d sums, %0d products, %0d empty results.",
                 tracker.requests, tracker.sums, tracker.products, tracker.empties);
        $display("Checked %0d result words across four idle/stall mixes and one long hold.",
                 tracker.words_checked);
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
